### rtl/mbpcd_pkg.sv
// Package for the MIDI byte parser / clock divider: command codes, the
// front-to-back command type and the status decode functions.
// No dependencies.
package mbpcd_pkg;

    // MIDI status bytes
    localparam logic [7:0] ST_NOTE_ON  = 8'd144;
    localparam logic [7:0] ST_NOTE_OFF = 8'd128;
    localparam logic [7:0] ST_BEND     = 8'd224;
    localparam logic [7:0] ST_CONTROL  = 8'd176;
    localparam logic [7:0] ST_START    = 8'd250;
    localparam logic [7:0] ST_CONTINUE = 8'd251;
    localparam logic [7:0] ST_STOP     = 8'd252;
    localparam logic [7:0] ST_CLOCK    = 8'd248;

    // Clock divider points
    localparam logic [4:0] TICK_FALL = 5'd11;
    localparam logic [4:0] TICK_LAST = 5'd23;

    // Saturation limit of the held-note count
    localparam logic [7:0] HELD_MAX = 8'd255;

    // Default depth of the front-to-back queue
    localparam int QUEUE_DEPTH_DEF = 2;

    // Message kinds carried to the back end
    localparam logic [2:0] MSG_NONE     = 3'd0;
    localparam logic [2:0] MSG_NOTE_ON  = 3'd1;
    localparam logic [2:0] MSG_NOTE_OFF = 3'd2;
    localparam logic [2:0] MSG_BEND     = 3'd3;
    localparam logic [2:0] MSG_CONTROL  = 3'd4;

    // Clock actions carried to the back end
    localparam logic [1:0] CLK_NONE  = 2'd0;
    localparam logic [1:0] CLK_START = 2'd1;
    localparam logic [1:0] CLK_STOP  = 2'd2;
    localparam logic [1:0] CLK_TICK  = 2'd3;

    typedef struct packed {
        logic [2:0] msg;
        logic [1:0] clk_op;
        logic [6:0] first;
        logic [7:0] second;
    } cmd_t;

    // Message kind implied by a status byte
    function automatic logic [2:0] msg_class(input logic [7:0] st);
        logic [2:0] k;
        begin
            unique case (st)
                ST_NOTE_ON:  k = MSG_NOTE_ON;
                ST_NOTE_OFF: k = MSG_NOTE_OFF;
                ST_BEND:     k = MSG_BEND;
                ST_CONTROL:  k = MSG_CONTROL;
                default:     k = MSG_NONE;
            endcase
            return k;
        end
    endfunction

    // Clock action implied by a status byte
    function automatic logic [1:0] clk_class(input logic [7:0] st);
        logic [1:0] k;
        begin
            unique case (st) inside
                ST_START, ST_CONTINUE: k = CLK_START;
                ST_STOP:               k = CLK_STOP;
                ST_CLOCK:              k = CLK_TICK;
                default:               k = CLK_NONE;
            endcase
            return k;
        end
    endfunction

endpackage

### rtl/mbpcd_if.sv
// Channel interfaces of the MIDI parser: received bytes in, events out.
// Valid/ready handshake. No dependencies.
interface mbpcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbpcd_out_if;
    logic        valid;
    logic        ready;
    logic        note_on;
    logic        note_off;
    logic [6:0]  note_number;
    logic [7:0]  velocity;
    logic        bend_event;
    logic [14:0] bend_value;
    logic        control_event;
    logic [6:0]  control_number;
    logic [7:0]  control_value;
    logic        clock_rise;
    logic        clock_fall;
    logic        all_released;

    modport source (
        output valid, output note_on, output note_off, output note_number,
        output velocity, output bend_event, output bend_value,
        output control_event, output control_number, output control_value,
        output clock_rise, output clock_fall, output all_released,
        input ready
    );
    modport sink (
        input valid, input note_on, input note_off, input note_number,
        input velocity, input bend_event, input bend_value,
        input control_event, input control_number, input control_value,
        input clock_rise, input clock_fall, input all_released,
        output ready
    );
endinterface

### rtl/mbpcd_front.sv
// Front end: accepts received bytes, tracks running status and the pending
// first data byte, and classifies each item into a command.
// Depends on mbpcd_pkg and mbpcd_if.
module mbpcd_front
    import mbpcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mbpcd_in_if.sink    in_ch,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_ready
);

    logic [7:0] status_reg, status_next;
    logic       await_reg, await_next;
    logic [6:0] first_reg, first_next;
    logic       accept;

    assign in_ch.ready = cmd_ready;
    assign cmd_valid   = in_ch.valid;
    assign accept      = in_ch.valid && cmd_ready;

    // Classify the byte against the current parser state
    always_comb
    begin
        status_next = status_reg;
        await_next  = await_reg;
        first_next  = first_reg;
        cmd.msg     = MSG_NONE;
        cmd.clk_op  = CLK_NONE;
        cmd.first   = first_reg;
        cmd.second  = in_ch.rx_byte;
        if (await_reg)
        begin
            // second byte completes the message, status is unchanged
            await_next = 1'b0;
            cmd.msg    = msg_class(status_reg);
        end
        else
        begin
            if (in_ch.rx_byte[7])
                status_next = in_ch.rx_byte;
            if (!in_ch.rx_byte[7] && msg_class(status_next) != MSG_NONE)
            begin
                // first data byte: hold it, item gives an empty result
                await_next = 1'b1;
                first_next = in_ch.rx_byte[6:0];
            end
            else
            begin
                cmd.clk_op = clk_class(status_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= '0;
            await_reg  <= 1'b0;
            first_reg  <= '0;
        end
        else if (accept)
        begin
            status_reg <= status_next;
            await_reg  <= await_next;
            first_reg  <= first_next;
        end
    end

endmodule

### rtl/mbpcd_queue.sv
// Short command queue between front and back end; push and pop may happen
// in the same cycle. Depends on mbpcd_pkg.
module mbpcd_queue
    import mbpcd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/mbpcd_back.sv
// Back end: carries out commands, keeps the held-note count and the
// 24-tick divider, and registers each result item.
// Depends on mbpcd_pkg and mbpcd_if.
module mbpcd_back
    import mbpcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_ready,
    mbpcd_out_if.source out_ch
);

    logic        valid_reg;
    logic [7:0]  held_reg, held_next;
    logic [4:0]  tick_reg, tick_next;
    logic        note_on_reg, note_on_next;
    logic        note_off_reg, note_off_next;
    logic [6:0]  note_num_reg, note_num_next;
    logic [7:0]  vel_reg, vel_next;
    logic        bend_reg, bend_next;
    logic [14:0] bend_val_reg, bend_val_next;
    logic        ctl_reg, ctl_next;
    logic [6:0]  ctl_num_reg, ctl_num_next;
    logic [7:0]  ctl_val_reg, ctl_val_next;
    logic        rise_reg, rise_next;
    logic        fall_reg, fall_next;
    logic        rel_reg, rel_next;
    logic        pop;

    assign cmd_ready = !valid_reg || out_ch.ready;
    assign pop       = cmd_valid && cmd_ready;

    // Message decode and held-note count
    always_comb
    begin
        held_next     = held_reg;
        note_on_next  = 1'b0;
        note_off_next = 1'b0;
        note_num_next = '0;
        vel_next      = '0;
        bend_next     = 1'b0;
        bend_val_next = '0;
        ctl_next      = 1'b0;
        ctl_num_next  = '0;
        ctl_val_next  = '0;
        unique case (cmd.msg)
            MSG_NOTE_ON:
            begin
                note_on_next  = 1'b1;
                note_num_next = cmd.first;
                vel_next      = cmd.second;
                if (held_reg != HELD_MAX)
                    held_next = held_reg + 1'b1;
            end
            MSG_NOTE_OFF:
            begin
                note_off_next = 1'b1;
                note_num_next = cmd.first;
                if (held_reg != '0)
                    held_next = held_reg - 1'b1;
            end
            MSG_BEND:
            begin
                // first + (second << 7), kept to 15 bits
                bend_next     = 1'b1;
                bend_val_next = {cmd.second, cmd.first};
            end
            MSG_CONTROL:
            begin
                ctl_next     = 1'b1;
                ctl_num_next = cmd.first;
                ctl_val_next = cmd.second;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
        rel_next = (held_next == '0);
    end

    // Clock divider
    always_comb
    begin
        tick_next = tick_reg;
        rise_next = 1'b0;
        fall_next = 1'b0;
        unique case (cmd.clk_op)
            CLK_START:
            begin
                rise_next = 1'b1;
                tick_next = '0;
            end
            CLK_STOP:
            begin
                fall_next = 1'b1;
            end
            CLK_TICK:
            begin
                fall_next = (tick_reg == TICK_FALL);
                if (tick_reg < TICK_LAST)
                    tick_next = tick_reg + 1'b1;
                else
                begin
                    // wrap, also recovers an out-of-range count
                    rise_next = 1'b1;
                    tick_next = '0;
                end
            end
            default:
            begin
                tick_next = tick_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            held_reg  <= '0;
            tick_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
                held_reg  <= held_next;
                tick_reg  <= tick_next;
            end
            else if (out_ch.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            note_on_reg  <= note_on_next;
            note_off_reg <= note_off_next;
            note_num_reg <= note_num_next;
            vel_reg      <= vel_next;
            bend_reg     <= bend_next;
            bend_val_reg <= bend_val_next;
            ctl_reg      <= ctl_next;
            ctl_num_reg  <= ctl_num_next;
            ctl_val_reg  <= ctl_val_next;
            rise_reg     <= rise_next;
            fall_reg     <= fall_next;
            rel_reg      <= rel_next;
        end
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.note_on        = note_on_reg;
    assign out_ch.note_off       = note_off_reg;
    assign out_ch.note_number    = note_num_reg;
    assign out_ch.velocity       = vel_reg;
    assign out_ch.bend_event     = bend_reg;
    assign out_ch.bend_value     = bend_val_reg;
    assign out_ch.control_event  = ctl_reg;
    assign out_ch.control_number = ctl_num_reg;
    assign out_ch.control_value  = ctl_val_reg;
    assign out_ch.clock_rise     = rise_reg;
    assign out_ch.clock_fall     = fall_reg;
    assign out_ch.all_released   = rel_reg;

endmodule

### rtl/midi_byte_parser_clock_divider_core.sv
// Top level of the MIDI byte parser with running status and clock divider.
// Depends on mbpcd_pkg, mbpcd_if, mbpcd_front, mbpcd_queue, mbpcd_back.
//
// Usage:
//   in_ch  carries one received MIDI byte per item (rx_byte).
//   out_ch carries exactly one result item per input item, in order:
//          note, pitch-bend and control-change events, clock_rise and
//          clock_fall of the 24-tick divider, and all_released.
//   A data byte that opens a two-byte message gives an item with every
//   event and clock field low.
// Timing:
//   An accepted byte is first written into the queue; the back end then
//   pops it and registers its result, which drives out_ch.valid and the
//   result fields until taken. Throughput is one item per cycle while
//   out_ch is ready; the front end decodes a byte in its accept cycle
//   and the back end updates its counters once per item.
// Stall:
//   A command queue (QUEUE_DEPTH entries) and the output register part the
//   two sides; while out_ch stalls, the queue fills and in_ch.ready drops
//   once it is full. No item is dropped.
// Reset:
//   rst_n clears running status, the pending byte, the held-note count,
//   the tick count and the queue; the block is ready right after reset.
module midi_byte_parser_clock_divider_core
    import mbpcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    mbpcd_in_if.sink    in_ch,
    mbpcd_out_if.source out_ch
);

    logic front_valid, front_ready;
    cmd_t front_cmd;
    logic back_valid, back_ready;
    cmd_t back_cmd;

    mbpcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    mbpcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_cmd   (front_cmd),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_cmd    (back_cmd),
        .pop_ready  (back_ready)
    );

    mbpcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_ready (back_ready),
        .out_ch    (out_ch)
    );

endmodule

### rtl/mbpcd_checker.sv
// Port-level checks for the MIDI parser core, bound to the top level.
// Depends on midi_byte_parser_clock_divider_core.
module mbpcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        note_on,
    input logic        note_off,
    input logic [6:0]  note_number,
    input logic [7:0]  velocity,
    input logic        bend_event,
    input logic [14:0] bend_value,
    input logic        control_event,
    input logic [6:0]  control_number,
    input logic [7:0]  control_value,
    input logic        clock_rise,
    input logic        clock_fall
);

    // A stalled result holds its events
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({note_on, note_off, bend_event, control_event,
                        clock_rise, clock_fall}))
        else $error("result changed while stalled");

    // One item raises at most one event or clock edge
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({note_on, note_off, bend_event, control_event,
                                clock_rise, clock_fall}))
        else $error("more than one event in one item");

    // Note fields are zero outside note events, velocity only on note-on
    a_note_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (note_on || note_off || note_number == 7'd0)
                      && (note_on || velocity == 8'd0))
        else $error("note fields set without note event");

    // Bend and control fields are zero outside their events
    a_other_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bend_event || bend_value == 15'd0)
                      && (control_event
                          || (control_number == 7'd0 && control_value == 8'd0)))
        else $error("bend or control fields set without event");

endmodule

bind midi_byte_parser_clock_divider_core mbpcd_checker u_mbpcd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .note_on        (out_ch.note_on),
    .note_off       (out_ch.note_off),
    .note_number    (out_ch.note_number),
    .velocity       (out_ch.velocity),
    .bend_event     (out_ch.bend_event),
    .bend_value     (out_ch.bend_value),
    .control_event  (out_ch.control_event),
    .control_number (out_ch.control_number),
    .control_value  (out_ch.control_value),
    .clock_rise     (out_ch.clock_rise),
    .clock_fall     (out_ch.clock_fall)
);
